// File: design/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the vector-matrix transform core.
// ----------------------------------------------------------------------------
`default_nettype none

package vmt_pkg;

    // number of vector components carried through the chain
    localparam int unsigned NUM_COMP  = 4;
    // Q16.16 words and full-width column sums
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned ACC_W     = PROD_W + 2;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned REG_W     = 64;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned IDX_W     = 3;

    // one in Q16.16, placed in the low or high half of a register
    localparam logic [REG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // configuration write as seen by every cell
    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     idx;
        logic [REG_W-1:0]     data;
    } t_cfg;

    // item moving from cell to cell: vector, running column sums, marker
    typedef struct packed {
        logic                       valid;
        logic                       last;
        t_word [NUM_COMP-1:0]       vec;
        t_acc  [NUM_COMP-1:0]       acc;
    } t_flow;

endpackage

`default_nettype wire

// File: design/vmt_cell.sv
// ----------------------------------------------------------------------------
// vmt_cell
// One matrix row: holds M[ROW][0..3], multiplies the vector's ROW component
// by the row and adds the four products into the passing column sums.
// ----------------------------------------------------------------------------
`default_nettype none

module vmt_cell #(
    parameter int unsigned ROW = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire vmt_pkg::t_cfg  i_cfg,
    input  wire vmt_pkg::t_flow i_flow,
    output vmt_pkg::t_flow      o_flow
);

    localparam logic [vmt_pkg::REG_W-1:0] DIAG =
        ((ROW % 2) == 0) ? vmt_pkg::ONE_LO : vmt_pkg::ONE_HI;
    localparam logic [vmt_pkg::REG_W-1:0] RST_01 = (ROW < 2) ? DIAG : '0;
    localparam logic [vmt_pkg::REG_W-1:0] RST_23 = (ROW < 2) ? '0 : DIAG;
    localparam logic [vmt_pkg::IDX_W-1:0] IDX_01 = vmt_pkg::IDX_W'(2 * ROW);
    localparam logic [vmt_pkg::IDX_W-1:0] IDX_23 = vmt_pkg::IDX_W'(2 * ROW + 1);

    logic [vmt_pkg::REG_W-1:0] r_m01;
    logic [vmt_pkg::REG_W-1:0] r_m23;
    vmt_pkg::t_flow            r_s1;
    vmt_pkg::t_prod [vmt_pkg::NUM_COMP-1:0] r_prod;
    vmt_pkg::t_prod [vmt_pkg::NUM_COMP-1:0] n_prod;
    vmt_pkg::t_flow            r_s2;
    vmt_pkg::t_flow            n_s2;
    vmt_pkg::t_word [vmt_pkg::NUM_COMP-1:0] w_elem;

    // row coefficients, written through the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m01 <= RST_01;
            r_m23 <= RST_23;
        end else if (i_cfg.we) begin
            if (i_cfg.idx == IDX_01) begin
                r_m01 <= i_cfg.data;
            end
            if (i_cfg.idx == IDX_23) begin
                r_m23 <= i_cfg.data;
            end
        end
    end

    // unpack the four signed elements of this row
    assign w_elem[0] = r_m01[31:0];
    assign w_elem[1] = r_m01[63:32];
    assign w_elem[2] = r_m23[31:0];
    assign w_elem[3] = r_m23[63:32];

    // products of this row, one lane per column
    always_comb begin
        for (int j = 0; j < vmt_pkg::NUM_COMP; j++) begin
            n_prod[j] = i_flow.vec[ROW] * w_elem[j];
        end
    end

    // add products into the column sums
    always_comb begin
        n_s2 = r_s1;
        for (int j = 0; j < vmt_pkg::NUM_COMP; j++) begin
            n_s2.acc[j] = r_s1.acc[j] + {{2{r_prod[j][vmt_pkg::PROD_W-1]}}, r_prod[j]};
        end
    end

    // two register stages: product, then sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1   <= i_flow;
            r_prod <= n_prod;
            r_s2   <= n_s2;
        end
    end

    assign o_flow = r_s2;

endmodule

`default_nettype wire

// File: design/vmt_sat.sv
// ----------------------------------------------------------------------------
// vmt_sat
// Output stage: floor shift of the column sums by 16, saturation to 32 bits,
// overflow flag, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vmt_sat #(
    parameter int unsigned DIM = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire vmt_pkg::t_flow i_flow,
    output logic                o_valid,
    output logic                o_last,
    output logic                o_sat,
    output vmt_pkg::t_word [vmt_pkg::NUM_COMP-1:0] o_vec
);

    localparam int unsigned SH_W = vmt_pkg::ACC_W - vmt_pkg::FRAC_W;

    logic                                   r_valid;
    logic                                   r_last;
    logic                                   r_sat;
    vmt_pkg::t_word [vmt_pkg::NUM_COMP-1:0] r_vec;
    logic                                   n_sat;
    vmt_pkg::t_word [vmt_pkg::NUM_COMP-1:0] n_vec;
    logic [SH_W-1:0]                        w_sh;

    // shift and clip each column, columns beyond the dimension read zero
    always_comb begin
        n_sat = 1'b0;
        w_sh  = '0;
        for (int j = 0; j < vmt_pkg::NUM_COMP; j++) begin
            w_sh     = i_flow.acc[j][vmt_pkg::ACC_W-1:vmt_pkg::FRAC_W];
            n_vec[j] = w_sh[vmt_pkg::WORD_W-1:0];
            if (j >= DIM) begin
                n_vec[j] = '0;
            end else if (!((&w_sh[SH_W-1:vmt_pkg::WORD_W-1]) ||
                           !(|w_sh[SH_W-1:vmt_pkg::WORD_W-1]))) begin
                n_sat    = 1'b1;
                n_vec[j] = w_sh[SH_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_flow.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_last <= i_flow.last;
            r_sat  <= n_sat;
            r_vec  <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_sat   = r_sat;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

// File: design/vector_matrix_transform_core.sv
// Vector-matrix transform: takes one row vector per clock and returns
// v * M in saturated signed Q16.16. Items flow through a chain of row cells,
// three when VEC_DIM is 3 and four otherwise, each two stages deep (multiply,
// then add into the column sums), followed by one output register; the
// sustained rate is one item per cycle while the chain is not held. The
// whole chain holds while the output register carries an item that is
// stalled; o_in_stall follows that condition. Matrix writes go straight into
// the owning cell and must be made while no item is in flight.
// ----------------------------------------------------------------------------
// vector_matrix_transform_core
// Top level: input packing, row-cell chain, output stage and flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_matrix_transform_core #(
    parameter int unsigned VEC_DIM = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [vmt_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vmt_pkg::REG_W-1:0]     i_cfg_data,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [31:0]            i_in_x,
    input  wire logic signed [31:0]            i_in_y,
    input  wire logic signed [31:0]            i_in_z,
    input  wire logic signed [31:0]            i_in_w,
    input  wire logic                          i_in_last,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [31:0]                 o_out_x,
    output logic signed [31:0]                 o_out_y,
    output logic signed [31:0]                 o_out_z,
    output logic signed [31:0]                 o_out_w,
    output logic                               o_out_last,
    output logic                               o_saturated
);

    localparam int unsigned DIM = (VEC_DIM == 3) ? 3 : 4;

    vmt_pkg::t_cfg                          w_cfg;
    vmt_pkg::t_flow                         w_chain [0:DIM];
    vmt_pkg::t_word [vmt_pkg::NUM_COMP-1:0] w_out_vec;
    logic                                   w_adv;

    // chain advances unless a finished item waits at the output
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // head of the chain: new item with zero column sums
    always_comb begin
        w_chain[0]        = '0;
        w_chain[0].valid  = i_in_valid;
        w_chain[0].last   = i_in_last;
        w_chain[0].vec[0] = i_in_x;
        w_chain[0].vec[1] = i_in_y;
        w_chain[0].vec[2] = i_in_z;
        w_chain[0].vec[3] = (DIM == 3) ? '0 : i_in_w;
    end

    // one cell per matrix row
    for (genvar k = 0; k < DIM; k++) begin : g_cell
        vmt_cell #(
            .ROW (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cfg   (w_cfg),
            .i_flow  (w_chain[k]),
            .o_flow  (w_chain[k+1])
        );
    end

    // floor shift, saturation and output register
    vmt_sat #(
        .DIM (DIM)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_flow  (w_chain[DIM]),
        .o_valid (o_out_valid),
        .o_last  (o_out_last),
        .o_sat   (o_saturated),
        .o_vec   (w_out_vec)
    );

    assign o_out_x = w_out_vec[0];
    assign o_out_y = w_out_vec[1];
    assign o_out_z = w_out_vec[2];
    assign o_out_w = w_out_vec[3];

`ifndef NO_ASSERTIONS
    // a held result must hold the whole chain
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("chain not held behind a stalled result");

    // overflow flag implies some component sits at a range limit
    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_out_x == 32'sh7fff_ffff || o_out_x == 32'sh8000_0000 ||
             o_out_y == 32'sh7fff_ffff || o_out_y == 32'sh8000_0000 ||
             o_out_z == 32'sh7fff_ffff || o_out_z == 32'sh8000_0000 ||
             o_out_w == 32'sh7fff_ffff || o_out_w == 32'sh8000_0000))
        else $error("overflow flag without a clipped component");

    // three-component build leaves the fourth output at zero
    a_dim3_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (DIM == 3)) |-> (o_out_w == '0))
        else $error("fourth component nonzero in three-component build");
`endif

endmodule

`default_nettype wire
